@@ design/asc2u64_pkg.sv @@
// ----------------------------------------------------------------------------
// asc2u64_pkg
// Shared types and codes for the ASCII to unsigned 64-bit numeral parser.
// ----------------------------------------------------------------------------
package asc2u64_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } in_t;

    typedef struct packed {
        logic [63:0] parsed_value;
        logic [1:0]  parse_status;
        logic [1:0]  radix_used;
    } out_t;

    // Decoded digit handed from the decoder to the accumulator step.
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } digit_t;

    // Prefix tracking modes.
    localparam logic [2:0] MODE_START  = 3'd0;
    localparam logic [2:0] MODE_ZERO   = 3'd1;
    localparam logic [2:0] MODE_HEXPRE = 3'd2;
    localparam logic [2:0] MODE_DEC    = 3'd3;
    localparam logic [2:0] MODE_OCT    = 3'd4;
    localparam logic [2:0] MODE_HEX    = 3'd5;

    // Status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_INVALID  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // Radix codes.
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_LOW_X = 8'h78;
    localparam logic [7:0] LETTER_MASK = 8'h1f;
    localparam logic [3:0] LETTER_BIAS = 4'd9;

endpackage

@@ design/asc2u64_digit.sv @@
// ----------------------------------------------------------------------------
// asc2u64_digit
// Decodes one ASCII character into a digit value for the selected radix.
// ----------------------------------------------------------------------------
module asc2u64_digit (
    input  logic [7:0]           char_code,
    input  logic [1:0]           radix,
    output asc2u64_pkg::digit_t  digit
);

    logic [7:0] letter_bits;

    assign letter_bits = char_code & asc2u64_pkg::LETTER_MASK;

    always_comb begin
        digit = '0;
        if (char_code inside {[8'h30:8'h37]}) begin
            digit.valid = 1'b1;
            digit.value = char_code[3:0];
        end else if (char_code inside {[8'h38:8'h39]}) begin
            digit.valid = (radix != asc2u64_pkg::RADIX_OCT);
            digit.value = char_code[3:0];
        end else if (char_code inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            // Letters map through their low five bits: 'a' and 'A' both give 10.
            digit.valid = (radix == asc2u64_pkg::RADIX_HEX);
            digit.value = letter_bits[3:0] + asc2u64_pkg::LETTER_BIAS;
        end
    end

endmodule

@@ design/asc2u64_step.sv @@
// ----------------------------------------------------------------------------
// asc2u64_step
// Next-state logic for one character: prefix tracking, digit accumulation
// with exact overflow detection, and the result fields for the last one.
// ----------------------------------------------------------------------------
module asc2u64_step (
    input  logic [2:0]          mode,
    input  logic [63:0]         acc,
    input  logic [1:0]          err,
    input  asc2u64_pkg::in_t    item,
    output logic [2:0]          mode_next,
    output logic [63:0]         acc_next,
    output logic [1:0]          err_next,
    output asc2u64_pkg::out_t   result
);

    logic                 take;
    logic [1:0]           radix;
    logic [1:0]           radix_out;
    asc2u64_pkg::digit_t  digit;
    logic [67:0]          product;
    logic [68:0]          sum;

    asc2u64_digit u_digit (
        .char_code (item.char_code),
        .radix     (radix),
        .digit     (digit)
    );

    always_comb begin
        take      = 1'b1;
        radix     = asc2u64_pkg::RADIX_DEC;
        mode_next = mode;
        case (mode)
            asc2u64_pkg::MODE_START: begin
                if (item.char_code == asc2u64_pkg::CHAR_ZERO) begin
                    mode_next = asc2u64_pkg::MODE_ZERO;
                    take      = 1'b0;
                end else begin
                    mode_next = asc2u64_pkg::MODE_DEC;
                end
            end
            asc2u64_pkg::MODE_ZERO: begin
                radix = asc2u64_pkg::RADIX_OCT;
                if (item.char_code == asc2u64_pkg::CHAR_LOW_X) begin
                    mode_next = asc2u64_pkg::MODE_HEXPRE;
                    take      = 1'b0;
                end else begin
                    mode_next = asc2u64_pkg::MODE_OCT;
                end
            end
            asc2u64_pkg::MODE_HEXPRE, asc2u64_pkg::MODE_HEX: begin
                radix     = asc2u64_pkg::RADIX_HEX;
                mode_next = asc2u64_pkg::MODE_HEX;
            end
            asc2u64_pkg::MODE_OCT: begin
                radix = asc2u64_pkg::RADIX_OCT;
            end
            default: begin
                mode_next = asc2u64_pkg::MODE_DEC;
            end
        endcase
    end

    // Multiply by 8, 10 or 16 as shifts and one add.
    always_comb begin
        case (radix)
            asc2u64_pkg::RADIX_OCT: product = {1'b0, acc, 3'b000};
            asc2u64_pkg::RADIX_HEX: product = {acc, 4'b0000};
            default:                product = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
        endcase
    end

    // Any bit above bit 63 means the exact value no longer fits.
    assign sum = {1'b0, product} + {65'd0, digit.value};

    always_comb begin
        acc_next = acc;
        err_next = err;
        if (take && err == asc2u64_pkg::STATUS_OK) begin
            if (!digit.valid) begin
                err_next = asc2u64_pkg::STATUS_INVALID;
            end else if (sum[68:64] != 5'd0) begin
                err_next = asc2u64_pkg::STATUS_OVERFLOW;
            end else begin
                acc_next = sum[63:0];
            end
        end
    end

    always_comb begin
        case (mode_next)
            asc2u64_pkg::MODE_ZERO, asc2u64_pkg::MODE_OCT:   radix_out = asc2u64_pkg::RADIX_OCT;
            asc2u64_pkg::MODE_HEXPRE, asc2u64_pkg::MODE_HEX: radix_out = asc2u64_pkg::RADIX_HEX;
            default:                                         radix_out = asc2u64_pkg::RADIX_DEC;
        endcase
    end

    always_comb begin
        result.parsed_value = (err_next == asc2u64_pkg::STATUS_OK) ? acc_next : 64'd0;
        result.parse_status = err_next;
        result.radix_used   = radix_out;
    end

endmodule

@@ design/ascii_to_uint64_parser.sv @@
// ----------------------------------------------------------------------------
// ascii_to_uint64_parser
// Streaming parser of an unsigned ASCII numeral (decimal, octal or 0x hex)
// into a 64-bit value with invalid-digit and overflow status.
// ----------------------------------------------------------------------------
// Output: the last character of a string passes from the input register into
// the result register, which drives m_valid, once that register is free.
// Rate: one character per cycle while no last character waits on a held result;
// the accumulator update (shift-add by the radix plus overflow check) is combinational.
// Reset: aresetn low synchronously empties both registers and returns the
// parser to the start of a string with a zero accumulator and no error.
// ----------------------------------------------------------------------------
module ascii_to_uint64_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  asc2u64_pkg::in_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output asc2u64_pkg::out_t   m_data
);

    logic              in_valid_reg, in_valid_next;
    asc2u64_pkg::in_t  in_data_reg;
    logic              out_valid_reg, out_valid_next;
    asc2u64_pkg::out_t out_data_reg;
    logic [2:0]        mode_reg, mode_next;
    logic [63:0]       acc_reg, acc_next;
    logic [1:0]        err_reg, err_next;
    asc2u64_pkg::out_t result;
    logic              out_free;
    logic              advance;
    logic              out_load;

    asc2u64_step u_step (
        .mode      (mode_reg),
        .acc       (acc_reg),
        .err       (err_reg),
        .item      (in_data_reg),
        .mode_next (mode_next),
        .acc_next  (acc_next),
        .err_next  (err_next),
        .result    (result)
    );

    // A character that ends no string can move on even while a result waits.
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (out_free || !in_data_reg.is_last);
    assign out_load = advance && in_data_reg.is_last;
    assign s_ready  = !in_valid_reg || advance;

    assign in_valid_next  = (s_valid && s_ready) ? 1'b1 : (in_valid_reg && !advance);
    assign out_valid_next = out_load || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= asc2u64_pkg::MODE_START;
            acc_reg       <= 64'd0;
            err_reg       <= asc2u64_pkg::STATUS_OK;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                if (in_data_reg.is_last) begin
                    mode_reg <= asc2u64_pkg::MODE_START;
                    acc_reg  <= 64'd0;
                    err_reg  <= asc2u64_pkg::STATUS_OK;
                end else begin
                    mode_reg <= mode_next;
                    acc_reg  <= acc_next;
                    err_reg  <= err_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (out_load) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Closing a string leaves the parser at the start with nothing carried over.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (mode_reg == asc2u64_pkg::MODE_START && acc_reg == 64'd0
                      && err_reg == asc2u64_pkg::STATUS_OK))
        else $error("parser state not cleared after end of string");

    // The first error is kept until the string ends.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != asc2u64_pkg::STATUS_OK && !out_load) |=> err_reg == $past(err_reg))
        else $error("latched error changed within a string");

    // An erroneous result carries a zero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.parse_status != asc2u64_pkg::STATUS_OK)
            |-> m_data.parsed_value == 64'd0)
        else $error("nonzero value reported with error status");

    // A waiting result is never overwritten by a new one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !out_load)
        else $error("result register loaded while occupied");

endmodule

@@ test/ascii_to_uint64_parser_test.sv @@
// ----------------------------------------------------------------------------
// ascii_to_uint64_parser_test
// Self-checking bench for the ASCII numeral parser. Character strings in all
// three bases are streamed in. They are well-formed numbers near the overflow
// boundaries, corrupted numbers and random noise. A scoreboard predicts each
// parse result and compares it field by field with the block output, while
// both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module ascii_to_uint64_parser_test;

    class parse_scoreboard;
        logic [2:0]         mode;
        logic [63:0]        acc;
        logic [1:0]         err;
        asc2u64_pkg::out_t  expected_q[$];
        int                 mismatches;
        int                 results_seen;

        function new();
            mode = asc2u64_pkg::MODE_START;
            acc = '0;
            err = asc2u64_pkg::STATUS_OK;
            mismatches = 0;
            results_seen = 0;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) $display("mismatch: %s", msg);
        endfunction

        // Adds one character in the given base, keeping the first error only.
        function void fold_digit(logic [7:0] c, logic [4:0] base);
            logic [63:0] d;
            logic [63:0] lim;
            bit          ok;
            if (err != asc2u64_pkg::STATUS_OK) return;
            ok = 1'b0;
            d = '0;
            if (c >= "0" && c <= "9") begin
                d = 64'(c - asc2u64_pkg::CHAR_ZERO);
                ok = (d < 64'(base));
            end else if (base == 5'd16 && ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")))
            begin
                d = 64'(c & asc2u64_pkg::LETTER_MASK) + 64'd9;
                ok = 1'b1;
            end
            if (!ok) begin
                err = asc2u64_pkg::STATUS_INVALID;
                return;
            end
            lim = (~64'd0 - d) / 64'(base);
            if (acc > lim) err = asc2u64_pkg::STATUS_OVERFLOW;
            else acc = acc * 64'(base) + d;
        endfunction

        function void note_char(asc2u64_pkg::in_t it);
            asc2u64_pkg::out_t res;
            case (mode)
                asc2u64_pkg::MODE_START: begin
                    if (it.char_code == asc2u64_pkg::CHAR_ZERO) mode = asc2u64_pkg::MODE_ZERO;
                    else begin
                        mode = asc2u64_pkg::MODE_DEC;
                        fold_digit(it.char_code, 5'd10);
                    end
                end
                asc2u64_pkg::MODE_ZERO: begin
                    if (it.char_code == asc2u64_pkg::CHAR_LOW_X) mode = asc2u64_pkg::MODE_HEXPRE;
                    else begin
                        mode = asc2u64_pkg::MODE_OCT;
                        fold_digit(it.char_code, 5'd8);
                    end
                end
                asc2u64_pkg::MODE_HEXPRE, asc2u64_pkg::MODE_HEX: begin
                    mode = asc2u64_pkg::MODE_HEX;
                    fold_digit(it.char_code, 5'd16);
                end
                asc2u64_pkg::MODE_OCT: fold_digit(it.char_code, 5'd8);
                default: begin
                    mode = asc2u64_pkg::MODE_DEC;
                    fold_digit(it.char_code, 5'd10);
                end
            endcase
            if (it.is_last) begin
                if (mode == asc2u64_pkg::MODE_ZERO || mode == asc2u64_pkg::MODE_OCT)
                    res.radix_used = asc2u64_pkg::RADIX_OCT;
                else if (mode == asc2u64_pkg::MODE_HEXPRE || mode == asc2u64_pkg::MODE_HEX)
                    res.radix_used = asc2u64_pkg::RADIX_HEX;
                else
                    res.radix_used = asc2u64_pkg::RADIX_DEC;
                res.parse_status = err;
                res.parsed_value = (err == asc2u64_pkg::STATUS_OK) ? acc : 64'd0;
                expected_q.push_back(res);
                mode = asc2u64_pkg::MODE_START;
                acc = '0;
                err = asc2u64_pkg::STATUS_OK;
            end
        endfunction

        function void check_result(asc2u64_pkg::out_t got);
            asc2u64_pkg::out_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result value=%0d status=%0d radix=%0d",
                                 got.parsed_value, got.parse_status, got.radix_used));
                return;
            end
            want = expected_q.pop_front();
            if (got.parsed_value !== want.parsed_value)
                report($sformatf("result %0d parsed_value expected %0d got %0d",
                                 results_seen, want.parsed_value, got.parsed_value));
            if (got.parse_status !== want.parse_status)
                report($sformatf("result %0d parse_status expected %0d got %0d",
                                 results_seen, want.parse_status, got.parse_status));
            if (got.radix_used !== want.radix_used)
                report($sformatf("result %0d radix_used expected %0d got %0d",
                                 results_seen, want.radix_used, got.radix_used));
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    asc2u64_pkg::in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    asc2u64_pkg::out_t m_data;

    parse_scoreboard sb = new();
    logic [7:0]      text_q[$];
    int              tx_gap_max = 11;
    int              chars_sent = 0;

    ascii_to_uint64_parser u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] digit_char(logic [63:0] d);
        if (d < 64'd10) return asc2u64_pkg::CHAR_ZERO + d[7:0];
        else if ($urandom_range(0, 1)) return "a" + d[7:0] - 8'd10;
        else return "A" + d[7:0] - 8'd10;
    endfunction

    function automatic void push_number(logic [63:0] v, logic [4:0] base, int zeros);
        logic [7:0] digits[$];
        if (base == 5'd16) begin
            text_q.push_back(asc2u64_pkg::CHAR_ZERO);
            text_q.push_back(asc2u64_pkg::CHAR_LOW_X);
        end else if (base == 5'd8) begin
            text_q.push_back(asc2u64_pkg::CHAR_ZERO);
        end
        repeat (zeros) text_q.push_back(asc2u64_pkg::CHAR_ZERO);
        do begin
            digits.push_front(digit_char(v % 64'(base)));
            v = v / 64'(base);
        end while (v != 0);
        foreach (digits[i]) text_q.push_back(digits[i]);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last);
        asc2u64_pkg::in_t item;
        int               gap;
        item.char_code = c;
        item.is_last = last;
        gap = $urandom_range(0, tx_gap_max);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        sb.note_char(item);
        chars_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    // Mostly well-formed numbers, some with values placed around the overflow point
    // of each base; the rest are corrupted numbers and raw noise.
    task automatic build_random_text();
        int          kind;
        int          pick;
        int          zeros;
        int          pos;
        bit          extra;
        logic [4:0]  base;
        logic [63:0] v;
        kind = $urandom_range(0, 99);
        if (kind >= 88) begin
            repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        pick = $urandom_range(0, 2);
        base = (pick == 0) ? 5'd10 : (pick == 1) ? 5'd8 : 5'd16;
        zeros = (base != 5'd10 && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        extra = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 5))
            0: v = 64'($urandom_range(0, 999));
            1, 2: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            3: v = ~64'd0 - 64'($urandom_range(0, 3));
            4: begin
                v = ~64'd0 / 64'(base) - 64'($urandom_range(0, 2));
                extra = 1'b1;
            end
            default: v = ~64'd0 >> $urandom_range(0, 8);
        endcase
        push_number(v, base, zeros);
        if (extra) text_q.push_back(digit_char(64'($urandom_range(0, base - 1))));
        if (kind >= 72) begin
            pos = $urandom_range(0, text_q.size() - 1);
            if ($urandom_range(0, 1)) text_q[pos] = 8'($urandom_range(0, 255));
            else text_q.insert(pos, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        int strings;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Lone zero, bare hex prefix, uppercase X, bad first character, bad
        // octal digit, mixed-case hex, plain decimal, lone 0x00 and 0xff bytes
        // and error followed by further characters.
        push_text("0");
        send_text();
        push_text("0x");
        send_text();
        push_text("0X1");
        send_text();
        push_text("Z");
        send_text();
        push_text("09");
        send_text();
        push_text("0xAf");
        send_text();
        push_text("7");
        send_text();
        text_q.push_back(8'h00);
        send_text();
        text_q.push_back(8'hff);
        send_text();
        push_text("1g2");
        send_text();

        strings = 0;
        while (chars_sent < 1270) begin
            if (strings % 16 == 0) tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
            build_random_text();
            send_text();
            strings++;
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin : result_side
        int  stall;
        int  rx_gap_max;
        bit  held_once;
        stall = 0;
        rx_gap_max = 11;
        held_once = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                sb.check_result(m_data);
                if (sb.results_seen % 32 == 0) rx_gap_max = (rx_gap_max == 0) ? 11 : 0;
                // One long hold-off so the sender backs up into the block.
                if (!held_once && sb.results_seen >= 20) begin
                    stall = 250;
                    held_once = 1'b1;
                end else begin
                    stall = $urandom_range(0, rx_gap_max);
                end
            end
        end
    end

    initial begin : watchdog
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
